@@ hdl/deti_pkg.sv @@
// ----------------------------------------------------------------------------
// deti_pkg
// Shared types and constants of the depth-energy table interpolator.
// ----------------------------------------------------------------------------
package deti_pkg;

  // Table geometry and fixed-point format.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int MAX_LAYERS  = 16;
  localparam int RANGE_W     = 5;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int DCNT_W      = 4;
  localparam int PROD_W      = 32 + FRAC_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_GROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP     = 2'd2;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_FIND = 2'd1;
  localparam logic [1:0] KIND_NEXT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] energy;
    logic [31:0] variance;
    logic [31:0] depth_pos;
    logic [3:0]  layer;
    logic        last_entry;
    logic [9:0]  start_index;
    logic [3:0]  prev_layer;
    logic        going_deeper;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_depth;
    logic [3:0]  out_layer;
    logic [31:0] out_energy;
    logic [31:0] out_variance;
    logic [9:0]  next_start;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] energy;
    logic [31:0] variance;
    logic [31:0] depth;
    logic [3:0]  layer;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BCLR, ST_BFIRST, ST_BSCAN, ST_BEND,
    ST_FRD0, ST_FCUR, ST_FSCAN, ST_FRDLO, ST_FRDHI, ST_FCAPHI,
    ST_FCLAMP, ST_FDIFF, ST_FGAP, ST_FDIV, ST_FMULD, ST_FMULV, ST_FADDV,
    ST_FOUT, ST_FSHORT, ST_NSEL, ST_NRD, ST_NCAP, ST_NOUT, ST_NEMPTY
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_ACCEPT, OP_BCLR, OP_BFIRST, OP_BSCAN, OP_BEND,
    OP_FCUR, OP_FSCAN, OP_FRDLO, OP_FRDHI, OP_FCAPHI, OP_FCLAMP,
    OP_FDIFF, OP_FGAP, OP_FDIV, OP_FMULD, OP_FMULV, OP_FADDV,
    OP_OUT_FIND, OP_OUT_SHORT, OP_NSEL, OP_NCAP, OP_OUT_NEXT, OP_OUT_EMPTY
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_IDX, RD_IDX_P1, RD_IDX_P2, RD_LO, RD_ZERO
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic short_tab;
    logic empty_tab;
    logic cur_last;
    logic scan_last;
    logic scan_stop;
    logic need_div;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ hdl/depth_energy_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// depth_energy_table_interpolator
// Depth-energy table with monotone search and linear interpolation.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ channel (valid/ready) and results leave on
// the out_ channel (valid/ready); each find or next-range item yields one
// result, loads and unused kinds yield none. The user must write registers on
// the cfg_ port only while the block is idle; the block does not enforce this.
// Operation. A load marked last builds the layer range starts, one entry per
// cycle. A find scans the entries, one per cycle from the single memory read
// port, then runs a bit-serial division and a shared multiplier for depth and
// variance. When the fraction is known to be zero or one the division is
// skipped.
// One item is worked on at a time; the next is taken as soon as the
// controller returns to idle, even while the last result waits in the
// output register.
// Reset. Counters, range starts and registers return to their defaults; the
// table contents are not cleared. A stalled receiver holds the result in the
// output register and stops the controller only when a new result is ready.
// ----------------------------------------------------------------------------
module depth_energy_table_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  deti_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output deti_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [deti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [deti_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  deti_pkg::ctl_cmd_t cmd;
  deti_pkg::dp_stat_t stat;

  // Sequencer.
  deti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_last  (in_data.last_entry),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath.
  deti_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

@@ hdl/deti_ctrl.sv @@
// ----------------------------------------------------------------------------
// deti_ctrl
// Sequencer for loads, range build, find and next-range queries.
// ----------------------------------------------------------------------------
module deti_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_kind,
  input  logic                in_last,
  input  deti_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output deti_pkg::ctl_cmd_t  cmd
);

  deti_pkg::ctl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deti_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.op     = deti_pkg::OP_NOP;
    cmd.rd_sel = deti_pkg::RD_IDX;
    unique case (state_r)
      deti_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = deti_pkg::OP_ACCEPT;
          priority if (in_kind == deti_pkg::KIND_LOAD) begin
            state_nxt = in_last ? deti_pkg::ST_BCLR : deti_pkg::ST_IDLE;
          end else if (in_kind == deti_pkg::KIND_FIND) begin
            state_nxt = stat.short_tab ? deti_pkg::ST_FSHORT : deti_pkg::ST_FRD0;
          end else if (in_kind == deti_pkg::KIND_NEXT) begin
            state_nxt = stat.empty_tab ? deti_pkg::ST_NEMPTY : deti_pkg::ST_NSEL;
          end else begin
            state_nxt = deti_pkg::ST_IDLE;
          end
        end
      end
      // Range build: one entry per cycle.
      deti_pkg::ST_BCLR: begin
        cmd.op     = deti_pkg::OP_BCLR;
        cmd.rd_sel = deti_pkg::RD_ZERO;
        state_nxt  = deti_pkg::ST_BFIRST;
      end
      deti_pkg::ST_BFIRST: begin
        cmd.op     = deti_pkg::OP_BFIRST;
        cmd.rd_sel = deti_pkg::RD_IDX_P1;
        state_nxt  = stat.cur_last ? deti_pkg::ST_BEND : deti_pkg::ST_BSCAN;
      end
      deti_pkg::ST_BSCAN: begin
        cmd.op     = deti_pkg::OP_BSCAN;
        cmd.rd_sel = deti_pkg::RD_IDX_P1;
        if (stat.cur_last) begin
          state_nxt = deti_pkg::ST_BEND;
        end
      end
      deti_pkg::ST_BEND: begin
        cmd.op    = deti_pkg::OP_BEND;
        state_nxt = deti_pkg::ST_IDLE;
      end
      // Find: scan, fetch the bracketing pair, clamp, divide if needed, interpolate.
      deti_pkg::ST_FRD0: begin
        state_nxt = deti_pkg::ST_FCUR;
      end
      deti_pkg::ST_FCUR: begin
        cmd.op     = deti_pkg::OP_FCUR;
        cmd.rd_sel = deti_pkg::RD_IDX_P1;
        state_nxt  = stat.cur_last ? deti_pkg::ST_FRDLO : deti_pkg::ST_FSCAN;
      end
      deti_pkg::ST_FSCAN: begin
        cmd.op     = deti_pkg::OP_FSCAN;
        cmd.rd_sel = deti_pkg::RD_IDX_P2;
        if (stat.scan_stop || stat.scan_last) begin
          state_nxt = deti_pkg::ST_FRDLO;
        end
      end
      deti_pkg::ST_FRDLO: begin
        cmd.op     = deti_pkg::OP_FRDLO;
        cmd.rd_sel = deti_pkg::RD_LO;
        state_nxt  = deti_pkg::ST_FRDHI;
      end
      deti_pkg::ST_FRDHI: begin
        cmd.op    = deti_pkg::OP_FRDHI;
        state_nxt = deti_pkg::ST_FCAPHI;
      end
      deti_pkg::ST_FCAPHI: begin
        cmd.op    = deti_pkg::OP_FCAPHI;
        state_nxt = deti_pkg::ST_FCLAMP;
      end
      deti_pkg::ST_FCLAMP: begin
        cmd.op    = deti_pkg::OP_FCLAMP;
        state_nxt = deti_pkg::ST_FDIFF;
      end
      deti_pkg::ST_FDIFF: begin
        cmd.op    = deti_pkg::OP_FDIFF;
        state_nxt = deti_pkg::ST_FGAP;
      end
      deti_pkg::ST_FGAP: begin
        cmd.op    = deti_pkg::OP_FGAP;
        state_nxt = stat.need_div ? deti_pkg::ST_FDIV : deti_pkg::ST_FMULD;
      end
      deti_pkg::ST_FDIV: begin
        cmd.op = deti_pkg::OP_FDIV;
        if (stat.div_done) begin
          state_nxt = deti_pkg::ST_FMULD;
        end
      end
      deti_pkg::ST_FMULD: begin
        cmd.op    = deti_pkg::OP_FMULD;
        state_nxt = deti_pkg::ST_FMULV;
      end
      deti_pkg::ST_FMULV: begin
        cmd.op    = deti_pkg::OP_FMULV;
        state_nxt = deti_pkg::ST_FADDV;
      end
      deti_pkg::ST_FADDV: begin
        cmd.op    = deti_pkg::OP_FADDV;
        state_nxt = deti_pkg::ST_FOUT;
      end
      deti_pkg::ST_FOUT: begin
        if (!stat.out_busy) begin
          cmd.op    = deti_pkg::OP_OUT_FIND;
          state_nxt = deti_pkg::ST_IDLE;
        end
      end
      deti_pkg::ST_FSHORT: begin
        if (!stat.out_busy) begin
          cmd.op    = deti_pkg::OP_OUT_SHORT;
          state_nxt = deti_pkg::ST_IDLE;
        end
      end
      // Next range: look up the range start and read that entry.
      deti_pkg::ST_NSEL: begin
        cmd.op    = deti_pkg::OP_NSEL;
        state_nxt = deti_pkg::ST_NRD;
      end
      deti_pkg::ST_NRD: begin
        state_nxt = deti_pkg::ST_NCAP;
      end
      deti_pkg::ST_NCAP: begin
        cmd.op    = deti_pkg::OP_NCAP;
        state_nxt = deti_pkg::ST_NOUT;
      end
      deti_pkg::ST_NOUT: begin
        if (!stat.out_busy) begin
          cmd.op    = deti_pkg::OP_OUT_NEXT;
          state_nxt = deti_pkg::ST_IDLE;
        end
      end
      deti_pkg::ST_NEMPTY: begin
        if (!stat.out_busy) begin
          cmd.op    = deti_pkg::OP_OUT_EMPTY;
          state_nxt = deti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = deti_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/deti_dp.sv @@
// ----------------------------------------------------------------------------
// deti_dp
// Datapath: entry memory, range starts, scan registers, divider, multiplier
// and output register.
// ----------------------------------------------------------------------------
module deti_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deti_pkg::ctl_cmd_t                  cmd,
  input  deti_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [deti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [deti_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                out_ready,
  output logic                                out_valid,
  output deti_pkg::out_item_t                 out_data,
  output deti_pkg::dp_stat_t                  stat
);

  localparam int IW = deti_pkg::IDX_W;
  localparam int CW = deti_pkg::CNT_W;
  localparam int RW = deti_pkg::RANGE_W;
  localparam int FB = deti_pkg::FRAC_BITS;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic                            depth_grows_r;
  logic [4:0]                      range_count_r;
  logic [15:0]                     min_gap_r;

  // Control state.
  logic [CW-1:0]                   count_r;
  logic                            closed_r;
  logic [IW-1:0]                   range_r [deti_pkg::MAX_LAYERS+1];
  logic                            out_valid_r;

  // Entry memory.
  deti_pkg::entry_t                mem_r [deti_pkg::TABLE_DEPTH];
  deti_pkg::entry_t                mem_q_r;

  // Working registers.
  logic [IW-1:0]                   idx_r;
  logic [3:0]                      old_r;
  deti_pkg::entry_t                cur_r, lo_r, hi_r;
  logic [31:0]                     e_r;
  logic [IW-1:0]                   ns_r;
  logic [IW-1:0]                   start_r;
  logic [3:0]                      prev_r;
  logic                            deeper_r;
  logic                            at_end_r, at_zero_r;
  logic [31:0]                     imag_r, dmag_r;
  logic                            cond_r;
  logic [31:0]                     rem_r;
  logic [FB-1:0]                   quo_r;
  logic [deti_pkg::FRAC_W-1:0]     frac_r;
  logic [deti_pkg::DCNT_W-1:0]     dcnt_r;
  logic [deti_pkg::PROD_W-1:0]     prod_r;
  logic [31:0]                     depth_res_r, var_res_r;
  deti_pkg::out_item_t             out_r;

  // Derived values.
  logic [CW-1:0]                   cnt_base, cnt_m1;
  logic                            wr_en;
  logic [IW-1:0]                   rd_addr;
  logic [IW-1:0]                   start_clamped;
  logic [RW-1:0]                   rc;
  logic                            gap_ok;
  logic [32:0]                     rem_sh, rem_sub;
  logic                            rem_ge;
  logic [FB-1:0]                   quo_nxt;
  logic [RW-1:0]                   nr;
  logic [IW-1:0]                   nk;
  logic [31:0]                     step;
  logic                            out_load;

  assign cnt_base = closed_r ? '0 : count_r;
  assign cnt_m1   = count_r - CW'(1);
  assign wr_en    = (cmd.op == deti_pkg::OP_ACCEPT) && (in_data.kind == deti_pkg::KIND_LOAD)
                    && (cnt_base < CW'(deti_pkg::TABLE_DEPTH));
  assign rc       = (range_count_r > RW'(deti_pkg::MAX_LAYERS))
                    ? RW'(deti_pkg::MAX_LAYERS) : range_count_r;
  assign start_clamped = ({1'b0, in_data.start_index} > cnt_m1)
                         ? cnt_m1[IW-1:0] : in_data.start_index;

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      deti_pkg::RD_IDX:    rd_addr = idx_r;
      deti_pkg::RD_IDX_P1: rd_addr = idx_r + IW'(1);
      deti_pkg::RD_IDX_P2: rd_addr = idx_r + IW'(2);
      deti_pkg::RD_LO:     rd_addr = (idx_r == '0) ? '0 : idx_r - IW'(1);
      deti_pkg::RD_ZERO:   rd_addr = '0;
      default:             rd_addr = idx_r;
    endcase
  end

  // Memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[cnt_base[IW-1:0]] <= '{energy:   in_data.energy,
                                   variance: in_data.variance,
                                   depth:    in_data.depth_pos,
                                   layer:    in_data.layer};
    end
    mem_q_r <= mem_r[rd_addr];
  end

  // Gap test, one restoring division step, next-range index.
  assign gap_ok  = cond_r && (imag_r != '0) && (imag_r >= {16'd0, min_gap_r});
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, imag_r};
  assign rem_ge  = (rem_sh >= {1'b0, imag_r});
  assign quo_nxt = {quo_r[FB-2:0], rem_ge};
  assign step    = prod_r[FB+31:FB];

  always_comb begin
    if (deeper_r) begin
      nr = {1'b0, prev_r} + RW'(1);
    end else begin
      nr = (prev_r == '0) ? '0 : {1'b0, prev_r} - RW'(1);
    end
    nk = ({1'b0, range_r[nr]} >= count_r) ? cnt_m1[IW-1:0] : range_r[nr];
  end

  assign out_load = (cmd.op == deti_pkg::OP_OUT_FIND) || (cmd.op == deti_pkg::OP_OUT_SHORT)
                    || (cmd.op == deti_pkg::OP_OUT_NEXT) || (cmd.op == deti_pkg::OP_OUT_EMPTY);

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_grows_r <= 1'b1;
      range_count_r <= 5'd1;
      min_gap_r     <= 16'd100;
      count_r       <= '0;
      closed_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int q = 0; q <= deti_pkg::MAX_LAYERS; q++) begin
        range_r[q] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          deti_pkg::CFG_DEPTH_GROWS: depth_grows_r <= cfg_wdata[0];
          deti_pkg::CFG_RANGE_COUNT: range_count_r <= cfg_wdata[4:0];
          deti_pkg::CFG_MIN_GAP:     min_gap_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        deti_pkg::OP_ACCEPT: begin
          if (in_data.kind == deti_pkg::KIND_LOAD) begin
            count_r  <= cnt_base + CW'(wr_en);
            closed_r <= in_data.last_entry;
          end
        end
        deti_pkg::OP_BCLR: begin
          for (int q = 0; q <= deti_pkg::MAX_LAYERS; q++) begin
            range_r[q] <= '0;
          end
        end
        deti_pkg::OP_BSCAN: begin
          // Every layer crossed by this step, within the range count, starts at the step's edge.
          for (int q = 0; q <= deti_pkg::MAX_LAYERS; q++) begin
            if (depth_grows_r) begin
              if ((mem_q_r.layer > old_r) && (RW'(q) > {1'b0, old_r})
                  && (RW'(q) <= {1'b0, mem_q_r.layer}) && (RW'(q) < rc)) begin
                range_r[q] <= idx_r - IW'(1);
              end
            end else begin
              if ((mem_q_r.layer < old_r) && (RW'(q) > {1'b0, mem_q_r.layer})
                  && (RW'(q) <= {1'b0, old_r}) && (RW'(q) <= rc)) begin
                range_r[q] <= idx_r;
              end
            end
          end
        end
        deti_pkg::OP_BEND: begin
          if (depth_grows_r) begin
            range_r[rc] <= cnt_m1[IW-1:0];
          end else if ({1'b0, old_r} <= rc) begin
            range_r[{1'b0, old_r}] <= cnt_m1[IW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      deti_pkg::OP_ACCEPT: begin
        e_r      <= in_data.energy;
        start_r  <= in_data.start_index;
        prev_r   <= in_data.prev_layer;
        deeper_r <= in_data.going_deeper;
        idx_r    <= start_clamped;
        ns_r     <= start_clamped;
      end
      deti_pkg::OP_BCLR: begin
        idx_r <= '0;
      end
      deti_pkg::OP_BFIRST: begin
        old_r <= mem_q_r.layer;
        idx_r <= IW'(1);
      end
      deti_pkg::OP_BSCAN: begin
        if (depth_grows_r ? (mem_q_r.layer > old_r) : (mem_q_r.layer < old_r)) begin
          old_r <= mem_q_r.layer;
        end
        idx_r <= idx_r + IW'(1);
      end
      deti_pkg::OP_FCUR: begin
        cur_r <= mem_q_r;
      end
      deti_pkg::OP_FSCAN: begin
        // Stop at a layer boundary or at the first entry below the query.
        priority if (cur_r.layer != mem_q_r.layer) begin
          e_r  <= cur_r.energy;
          ns_r <= idx_r + IW'(1);
        end else if (cur_r.energy < e_r) begin
          ns_r <= idx_r;
        end else begin
          cur_r <= mem_q_r;
          idx_r <= idx_r + IW'(1);
        end
      end
      deti_pkg::OP_FRDLO: begin
        at_end_r  <= ({1'b0, idx_r} == cnt_m1);
        at_zero_r <= (idx_r == '0);
        if (idx_r == '0) begin
          idx_r <= IW'(1);
        end
      end
      deti_pkg::OP_FRDHI: begin
        lo_r <= mem_q_r;
      end
      deti_pkg::OP_FCAPHI: begin
        hi_r <= mem_q_r;
      end
      deti_pkg::OP_FCLAMP: begin
        priority if (at_end_r) begin
          if (e_r < hi_r.energy) begin
            e_r <= hi_r.energy;
          end
        end else if (at_zero_r) begin
          if (e_r > lo_r.energy) begin
            e_r <= lo_r.energy;
          end
        end else begin
          e_r <= e_r;
        end
      end
      deti_pkg::OP_FDIFF: begin
        imag_r <= abs_diff(hi_r.energy, lo_r.energy);
        dmag_r <= abs_diff(e_r, lo_r.energy);
        cond_r <= (e_r == lo_r.energy)
                  || ((e_r > lo_r.energy) == (hi_r.energy > lo_r.energy));
      end
      deti_pkg::OP_FGAP: begin
        rem_r  <= dmag_r;
        quo_r  <= '0;
        dcnt_r <= '0;
        priority if (!gap_ok) begin
          frac_r <= '0;
        end else if (dmag_r >= imag_r) begin
          frac_r <= {1'b1, {FB{1'b0}}};
        end else begin
          frac_r <= '0;
        end
      end
      deti_pkg::OP_FDIV: begin
        rem_r  <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        quo_r  <= quo_nxt;
        dcnt_r <= dcnt_r + deti_pkg::DCNT_W'(1);
        if (dcnt_r == deti_pkg::DCNT_W'(FB - 1)) begin
          frac_r <= {1'b0, quo_nxt};
        end
      end
      deti_pkg::OP_FMULD: begin
        prod_r <= abs_diff(hi_r.depth, lo_r.depth) * frac_r;
      end
      deti_pkg::OP_FMULV: begin
        depth_res_r <= (hi_r.depth >= lo_r.depth) ? lo_r.depth + step : lo_r.depth - step;
        prod_r      <= abs_diff(hi_r.variance, lo_r.variance) * frac_r;
      end
      deti_pkg::OP_FADDV: begin
        var_res_r <= (hi_r.variance >= lo_r.variance)
                     ? lo_r.variance + step : lo_r.variance - step;
      end
      deti_pkg::OP_OUT_FIND: begin
        out_r <= '{out_depth: depth_res_r, out_layer: hi_r.layer, out_energy: e_r,
                   out_variance: var_res_r, next_start: ns_r, status: 1'b0};
      end
      deti_pkg::OP_OUT_SHORT: begin
        out_r <= '{out_depth: '0, out_layer: '0, out_energy: '0,
                   out_variance: '0, next_start: start_r, status: 1'b1};
      end
      deti_pkg::OP_NSEL: begin
        idx_r <= nk;
      end
      deti_pkg::OP_NCAP: begin
        hi_r <= mem_q_r;
      end
      deti_pkg::OP_OUT_NEXT: begin
        out_r <= '{out_depth: hi_r.depth, out_layer: hi_r.layer, out_energy: hi_r.energy,
                   out_variance: hi_r.variance, next_start: idx_r,
                   status: (count_r < CW'(2))};
      end
      deti_pkg::OP_OUT_EMPTY: begin
        out_r <= '{out_depth: '0, out_layer: '0, out_energy: '0,
                   out_variance: '0, next_start: '0, status: 1'b1};
      end
      default: ;
    endcase
  end

  // Status towards the controller.
  assign stat.short_tab = (count_r < CW'(2));
  assign stat.empty_tab = (count_r == '0);
  assign stat.cur_last  = ({1'b0, idx_r} == cnt_m1);
  assign stat.scan_last = ({1'b0, idx_r} + CW'(1) == cnt_m1);
  assign stat.scan_stop = (cur_r.layer != mem_q_r.layer) || (cur_r.energy < e_r);
  assign stat.need_div  = gap_ok && (dmag_r < imag_r);
  assign stat.div_done  = (dcnt_r == deti_pkg::DCNT_W'(FB - 1));
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/deti_checker.sv @@
// ----------------------------------------------------------------------------
// deti_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module deti_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input deti_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input deti_pkg::out_item_t out_data
);

  // A result waiting for the receiver holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result appears in the cycle right after any transfer in.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A find keeps the block busy in the following cycle.
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.kind == deti_pkg::KIND_FIND) |=> !in_ready)
    else $error("input taken during a find");

  // Reset leaves no pending result.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind depth_energy_table_interpolator deti_checker u_deti_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Depth-energy table interpolator testbench
// Loads tables through the input channel, runs find and next-range queries
// and checks every result against a predictor kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: its own copy of the table, the layer range starts and the
// registers, and a queue of expected results.
class deti_scoreboard;
  logic [31:0] tab_energy[1024];
  logic [31:0] tab_var[1024];
  logic [31:0] tab_depth[1024];
  logic [3:0]  tab_layer[1024];
  int unsigned n_entries;
  int unsigned layer_first[17];
  bit          closed;
  bit          grows;
  int unsigned range_lim;
  int unsigned gap_min;
  deti_pkg::out_item_t pending[$];
  int unsigned n_errors;

  function new();
    n_entries = 0;
    closed = 0;
    grows = 1;
    range_lim = 1;
    gap_min = 100;
    n_errors = 0;
    foreach (layer_first[k]) layer_first[k] = 0;
  endfunction

  function void set_first(int unsigned r, int unsigned rc, int unsigned v);
    if (r <= rc && r <= 16) layer_first[r] = v;
  endfunction

  // Layer range starts, built when the table is closed.
  function void build_ranges();
    int unsigned rc, prev, l;
    rc = (range_lim > 16) ? 16 : range_lim;
    foreach (layer_first[k]) layer_first[k] = 0;
    if (n_entries == 0) return;
    prev = tab_layer[0];
    set_first(prev, rc, 0);
    for (int unsigned i = 1; i < n_entries; i++) begin
      l = tab_layer[i];
      if (grows && l > prev) begin
        for (int unsigned r = prev + 1; r <= l && r < rc; r++) set_first(r, rc, i - 1);
        prev = l;
      end else if (!grows && l < prev) begin
        for (int unsigned r = l; r < prev; r++) set_first(r + 1, rc, i);
        prev = l;
      end
    end
    if (grows) set_first(rc, rc, n_entries - 1);
    else set_first(prev, rc, n_entries - 1);
  endfunction

  function logic [31:0] blend(logic [31:0] lo, logic [31:0] hi, logic [63:0] frac);
    logic [63:0] mag, step;
    mag = (hi >= lo) ? 64'(hi - lo) : 64'(lo - hi);
    step = (mag * frac) >> 16;
    return (hi >= lo) ? lo + step[31:0] : lo - step[31:0];
  endfunction

  function deti_pkg::out_item_t find_depth(deti_pkg::in_item_t it);
    deti_pkg::out_item_t r;
    logic [31:0] e, el, eh, dmag, imag;
    int unsigned s, i, ns, lo, hi;
    logic [63:0] frac;
    r = '0;
    e = it.energy;
    s = it.start_index;
    frac = 0;
    if (n_entries < 2) begin
      r.next_start = it.start_index;
      r.status = 1'b1;
      return r;
    end
    if (s > n_entries - 1) s = n_entries - 1;
    ns = s;
    for (i = s; i < n_entries - 1; i++) begin
      if (tab_layer[i] != tab_layer[i + 1]) begin
        e = tab_energy[i];
        ns = i + 1;
        break;
      end
      if (tab_energy[i] < e) begin
        ns = i;
        break;
      end
    end
    // Clamp at the table ends.
    if (i == n_entries - 1) begin
      if (e < tab_energy[i]) e = tab_energy[i];
    end else if (i == 0) begin
      if (e > tab_energy[0]) e = tab_energy[0];
      i = 1;
    end
    lo = i - 1;
    hi = i;
    el = tab_energy[lo];
    eh = tab_energy[hi];
    imag = (eh >= el) ? eh - el : el - eh;
    dmag = (e >= el) ? e - el : el - e;
    if (imag != 0 && imag >= gap_min && (e == el || ((e > el) == (eh > el)))) begin
      frac = ({32'd0, dmag} << 16) / {32'd0, imag};
      if (frac > 64'h10000) frac = 64'h10000;
    end
    r.out_depth = blend(tab_depth[lo], tab_depth[hi], frac);
    r.out_layer = tab_layer[hi];
    r.out_energy = e;
    r.out_variance = blend(tab_var[lo], tab_var[hi], frac);
    r.next_start = ns[9:0];
    return r;
  endfunction

  function deti_pkg::out_item_t next_range(deti_pkg::in_item_t it);
    deti_pkg::out_item_t r;
    int unsigned d, g, k;
    r = '0;
    if (n_entries == 0) begin
      r.status = 1'b1;
      return r;
    end
    d = it.prev_layer;
    g = it.going_deeper ? d + 1 : ((d == 0) ? 0 : d - 1);
    if (g > 16) g = 16;
    k = layer_first[g];
    if (k >= n_entries) k = n_entries - 1;
    r.out_depth = tab_depth[k];
    r.out_layer = tab_layer[k];
    r.out_energy = tab_energy[k];
    r.out_variance = tab_var[k];
    r.next_start = k[9:0];
    r.status = (n_entries < 2);
    return r;
  endfunction

  // Note an accepted input transfer.
  function void note_input(deti_pkg::in_item_t it);
    case (it.kind)
      deti_pkg::KIND_LOAD: begin
        if (closed) begin
          n_entries = 0;
          closed = 0;
        end
        if (n_entries < 1024) begin
          tab_energy[n_entries] = it.energy;
          tab_var[n_entries] = it.variance;
          tab_depth[n_entries] = it.depth_pos;
          tab_layer[n_entries] = it.layer;
          n_entries++;
        end
        if (it.last_entry) begin
          build_ranges();
          closed = 1;
        end
      end
      deti_pkg::KIND_FIND: pending.push_back(find_depth(it));
      deti_pkg::KIND_NEXT: pending.push_back(next_range(it));
      default: ;
    endcase
  endfunction

  // Check one result transfer against the oldest expectation.
  function void check_result(deti_pkg::out_item_t got);
    deti_pkg::out_item_t x;
    if (pending.size() == 0) begin
      $error("unexpected result %h", got);
      n_errors++;
      return;
    end
    x = pending.pop_front();
    if (got.out_depth !== x.out_depth) begin
      $error("out_depth: expected %h, got %h", x.out_depth, got.out_depth);
      n_errors++;
    end
    if (got.out_layer !== x.out_layer) begin
      $error("out_layer: expected %h, got %h", x.out_layer, got.out_layer);
      n_errors++;
    end
    if (got.out_energy !== x.out_energy) begin
      $error("out_energy: expected %h, got %h", x.out_energy, got.out_energy);
      n_errors++;
    end
    if (got.out_variance !== x.out_variance) begin
      $error("out_variance: expected %h, got %h", x.out_variance, got.out_variance);
      n_errors++;
    end
    if (got.next_start !== x.next_start) begin
      $error("next_start: expected %h, got %h", x.next_start, got.next_start);
      n_errors++;
    end
    if (got.status !== x.status) begin
      $error("status: expected %h, got %h", x.status, got.status);
      n_errors++;
    end
  endfunction
endclass

module testbench;

  // Item kind that the block ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  deti_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  deti_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [deti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [deti_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  deti_scoreboard sb;
  bit calm;
  int unsigned quiet_cycles = 0;

  depth_energy_table_interpolator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: random stall bursts, none in the calm part of the run.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog over cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one item; the transfer is noted in the scoreboard when accepted.
  // Valid stays high after the transfer until the next item or a pause.
  task automatic send(deti_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Pause the sender until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [deti_pkg::CFG_IDX_W-1:0] idx,
                           logic [deti_pkg::CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == deti_pkg::CFG_DEPTH_GROWS) sb.grows = v[0];
    else if (idx == deti_pkg::CFG_RANGE_COUNT) sb.range_lim = v[4:0];
    else sb.gap_min = v;
    @(posedge clk);
  endtask

  function automatic deti_pkg::in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(deti_pkg::in_item_t)-1:0];
  endfunction

  // Load a table with falling energies that may wrap in a long table, and layers following depth order.
  task automatic load_table(int unsigned n, bit grows);
    deti_pkg::in_item_t it;
    logic [31:0] e;
    int unsigned lay;
    e = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom | 32'h8000_0000;
    lay = grows ? $urandom_range(0, 2) : $urandom_range(13, 15);
    for (int unsigned i = 0; i < n; i++) begin
      it = rand_item();
      it.kind = deti_pkg::KIND_LOAD;
      it.energy = e;
      it.layer = 4'(lay);
      it.last_entry = (i == n - 1);
      send(it);
      e = e - 32'($urandom_range(0, 3) == 0 ? $urandom_range(0, 150)
                                             : $urandom_range(0, 1 << 24));
      if ($urandom_range(0, 3) == 0) begin
        if (grows && lay < 15) lay++;
        else if (!grows && lay > 0) lay--;
      end
    end
  endtask

  task automatic query();
    deti_pkg::in_item_t it;
    it = rand_item();
    it.kind = $urandom_range(0, 2) != 0 ? deti_pkg::KIND_FIND : deti_pkg::KIND_NEXT;
    if ($urandom_range(0, 1)) it.start_index = 10'($urandom_range(0, 40));
    send(it);
  endtask

  initial begin
    deti_pkg::in_item_t it;
    int unsigned n;
    sb = new();
    calm = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table queries, an unused kind, then a one-entry table and its queries.
    it = '0;
    it.kind = deti_pkg::KIND_NEXT;
    send(it);
    it.kind = deti_pkg::KIND_FIND;
    it.start_index = 10'h3FF;
    send(it);
    it.kind = KIND_UNUSED;
    send(it);
    it = '1;
    it.kind = deti_pkg::KIND_LOAD;
    send(it);
    it.kind = deti_pkg::KIND_FIND;
    send(it);
    it.kind = deti_pkg::KIND_NEXT;
    it.going_deeper = 1'b0;
    send(it);
    it.prev_layer = 4'd0;
    send(it);
    drain();

    // Extreme register settings with small tables.
    write_reg(deti_pkg::CFG_DEPTH_GROWS, 16'd0);
    write_reg(deti_pkg::CFG_RANGE_COUNT, 16'd31);
    write_reg(deti_pkg::CFG_MIN_GAP, 16'hFFFF);
    load_table(6, 0);
    it = '0;
    it.kind = deti_pkg::KIND_FIND;
    send(it);
    it.energy = '1;
    it.start_index = 10'h3FF;
    send(it);
    it = '1;
    it.kind = deti_pkg::KIND_NEXT;
    send(it);
    drain();
    write_reg(deti_pkg::CFG_DEPTH_GROWS, 16'd1);
    write_reg(deti_pkg::CFG_RANGE_COUNT, 16'd16);
    write_reg(deti_pkg::CFG_MIN_GAP, 16'd0);
    load_table(8, 1);
    for (int k = 0; k < 6; k++) query();
    drain();

    // Random phases: a table then queries, with new settings between phases.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 10) calm = 1;
      write_reg(deti_pkg::CFG_DEPTH_GROWS, 16'($urandom_range(0, 1)));
      write_reg(deti_pkg::CFG_RANGE_COUNT,
                (ph % 5 == 0) ? 16'd1 : 16'($urandom_range(0, 31)));
      write_reg(deti_pkg::CFG_MIN_GAP,
                (ph % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 300)));
      n = (ph == 7) ? 600 : $urandom_range(2, 12);
      load_table(n, sb.grows);
      n = $urandom_range(10, 20);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 30) == 0) begin
          it = rand_item();
          it.kind = KIND_UNUSED;
          send(it);
        end
        query();
      end
      drain();
    end

    drain();
    if (sb.n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
